>>> hw/rtl/weighted_median_cell_split_defines.svh
// ----------------------------------------------------------------------------
// weighted median cell split: assertion macros
// shared property wrappers, clocked on clk_i and quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MEDIAN_CELL_SPLIT_DEFINES_SVH
`define WEIGHTED_MEDIAN_CELL_SPLIT_DEFINES_SVH

// plain clocked property
`define WMCS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("weighted median split check failed");

// antecedent in one cycle, consequent in the next
`define WMCS_ASSERT_NEXT(name, ante, cons) \
  `WMCS_ASSERT(name, (ante) |=> (cons))

`endif

>>> hw/rtl/wmcs_pkg.sv
// ----------------------------------------------------------------------------
// wmcs_pkg
// types, widths and codes shared by the weighted median cell split block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wmcs_pkg;

  localparam int unsigned MaxCellsDef = 32;
  localparam int unsigned QueueDepth  = 2;

  localparam int unsigned IdxW  = 6;
  localparam int unsigned KeyW  = 24;
  localparam int unsigned AreaW = 32;
  localparam int unsigned SumW  = 38;
  localparam int unsigned RhW   = 16;
  localparam int unsigned ProdW = 64;
  localparam int unsigned MulAW = 38;
  localparam int unsigned MulBW = 24;
  localparam int unsigned DenW  = 38;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegCutAlongY = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBoxLeft   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBoxRight  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBoxBottom = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBoxTop    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRowHeight = 3'd5;

  typedef struct packed {
    logic [IdxW-1:0]  cell_index;
    logic [KeyW-1:0]  cell_x;
    logic [KeyW-1:0]  cell_y;
    logic [AreaW-1:0] footprint;
    logic             last_cell;
  } in_beat_t;

  typedef struct packed {
    logic [IdxW-1:0] sorted_cell_index;
    logic            goes_low;
    logic [KeyW-1:0] space_cut_line;
    logic [KeyW-1:0] cell_cut_coord;
    logic [SumW-1:0] area_below;
    logic [SumW-1:0] area_above;
    logic            last_result;
  } out_beat_t;

  // queued command: the beat plus whether the store still has room
  typedef struct packed {
    in_beat_t beat;
    logic     keep;
  } cmd_t;

  typedef struct packed {
    logic            cut_along_y;
    logic [KeyW-1:0] box_left;
    logic [KeyW-1:0] box_right;
    logic [KeyW-1:0] box_bottom;
    logic [KeyW-1:0] box_top;
    logic [RhW-1:0]  row_height;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [KeyW-1:0]  x;
    logic [KeyW-1:0]  y;
    logic [AreaW-1:0] area;
  } entry_t;

  typedef enum logic {
    ArithMul,
    ArithDiv
  } arith_op_e;

  typedef struct packed {
    logic             start;
    arith_op_e        op;
    logic [ProdW-1:0] opa;
    logic [DenW-1:0]  opb;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] result;
  } arith_rsp_t;

endpackage

>>> hw/rtl/wmcs_fifo.sv
// ----------------------------------------------------------------------------
// wmcs_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmcs_fifo import wmcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic pop_valid_o,
  output cmd_t pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == CntW'(QueueDepth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/wmcs_front.sv
// ----------------------------------------------------------------------------
// wmcs_front
// takes input beats and marks whether each still fits in the cell store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmcs_front import wmcs_pkg::*; #(
  parameter int unsigned MAX_CELLS = MaxCellsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_beat_t in_data_i,
  output logic     in_stall_o,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_data_o
);

  localparam int unsigned CntW = $clog2(MAX_CELLS + 1);

  logic [CntW-1:0] fill_q;

  assign in_stall_o     = q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i;
  assign q_data_o.beat  = in_data_i;
  assign q_data_o.keep  = (fill_q < CntW'(MAX_CELLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (q_push_o) begin
      if (in_data_i.last_cell) begin
        fill_q <= '0;
      end else if (q_data_o.keep) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/wmcs_arith.sv
// ----------------------------------------------------------------------------
// wmcs_arith
// shared shift-add multiplier and restoring divider, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmcs_arith import wmcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(ProdW + 1);

  logic             busy_q, done_q;
  arith_op_e        op_q;
  logic [StepW-1:0] step_q;
  logic [ProdW-1:0] acc_q, a_q;
  logic [DenW-1:0]  b_q, rem_q;
  logic [DenW:0]    rem_sh;
  logic             rem_ge;

  assign rem_sh      = {rem_q, a_q[ProdW-1]};
  assign rem_ge      = (rem_sh >= {1'b0, b_q});
  assign rsp_o.done  = done_q;
  assign rsp_o.result = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ArithMul;
      step_q <= '0;
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        acc_q  <= '0;
        rem_q  <= '0;
        if (req_i.op == ArithMul) begin
          a_q    <= ProdW'(req_i.opa[MulAW-1:0]);
          b_q    <= DenW'(req_i.opb[MulBW-1:0]);
          step_q <= StepW'(MulBW);
        end else begin
          a_q    <= req_i.opa;
          b_q    <= req_i.opb;
          step_q <= StepW'(ProdW);
        end
      end else if (busy_q) begin
        if (op_q == ArithMul) begin
          if (b_q[0]) begin
            acc_q <= acc_q + a_q;
          end
          a_q <= {a_q[ProdW-2:0], 1'b0};
          b_q <= {1'b0, b_q[DenW-1:1]};
        end else begin
          // one quotient bit per step
          rem_q <= rem_ge ? DenW'(rem_sh - {1'b0, b_q}) : rem_sh[DenW-1:0];
          acc_q <= {acc_q[ProdW-2:0], rem_ge};
          a_q   <= {a_q[ProdW-2:0], 1'b0};
        end
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/wmcs_back.sv
// ----------------------------------------------------------------------------
// wmcs_back
// cell store, selection sort, split search and result emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmcs_back import wmcs_pkg::*; #(
  parameter int unsigned MAX_CELLS = MaxCellsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  cmd_t      q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned CntW = $clog2(MAX_CELLS + 1);

  typedef enum logic [4:0] {
    StLoad, StSortRd, StSortFirst, StSortScan, StSwapA, StSwapB,
    StPrep, StRowsW, StLineMul, StLineMulW, StLineDiv, StLineDivW,
    StE0Mul, StE0MulW, StRMul, StRMulW,
    StWalkRd, StWalkDat, StWalkMul, StWalkMulW, StWalkCmp,
    StXMul, StXMulW, StXDiv, StXDivW,
    StEmitRd, StEmitOut
  } state_e;

  function automatic logic [KeyW-1:0] key_of(entry_t e, logic cut);
    return cut ? e.y : e.x;
  endfunction

  state_e           state_q;
  entry_t           mem [MAX_CELLS];
  entry_t           rd_data_q, mem_wd, cur_q, min_q, ent_q;
  logic [AW-1:0]    rd_addr, mem_wa, mi_q;
  logic             mem_we;
  logic [CntW-1:0]  cnt_q, i_q, j_q, pj_q, split_q;
  logic [SumW-1:0]  total_q, prefix_q, below_q, prefix_nx;
  logic [KeyW-1:0]  rows_q, line_q, cutkey_q, height, width;
  logic [ProdW-1:0] tmp_q, best_q, r_q, l_q, diff;
  logic             cand_q, out_valid_q, l_ge_r, upd, brk, last_i, out_free;
  out_beat_t        out_q;
  arith_req_t       areq;
  arith_rsp_t       arsp;

  wmcs_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .rsp_o  (arsp)
  );

  assign height    = (cfg_i.box_top >= cfg_i.box_bottom) ?
                     cfg_i.box_top - cfg_i.box_bottom : '0;
  assign width     = (cfg_i.box_right >= cfg_i.box_left) ?
                     cfg_i.box_right - cfg_i.box_left : '0;
  assign q_pop_o   = (state_q == StLoad) && q_valid_i;
  assign prefix_nx = prefix_q + SumW'(rd_data_q.area);
  assign l_ge_r    = (l_q >= r_q);
  assign diff      = l_ge_r ? l_q - r_q : r_q - l_q;
  assign last_i    = (i_q == cnt_q - 1'b1);
  assign upd       = (i_q == '0) || (cand_q && (diff < best_q));
  assign brk       = !cand_q || (cfg_i.cut_along_y ? l_ge_r : (l_q > r_q)) || last_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // memory ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_q[AW-1:0];
    mem_wd.idx  = q_data_i.beat.cell_index;
    mem_wd.x    = q_data_i.beat.cell_x;
    mem_wd.y    = q_data_i.beat.cell_y;
    mem_wd.area = q_data_i.beat.footprint;
    rd_addr = i_q[AW-1:0];
    case (state_q)
      StLoad: begin
        mem_we = q_pop_o && q_data_i.keep;
      end
      StSortFirst, StSortScan: begin
        rd_addr = j_q[AW-1:0];
      end
      StSwapA: begin
        mem_we = 1'b1;
        mem_wa = mi_q;
        mem_wd = cur_q;
      end
      StSwapB: begin
        mem_we = 1'b1;
        mem_wa = i_q[AW-1:0];
        mem_wd = min_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  // requests to the shared arithmetic unit
  always_comb begin
    areq.start = 1'b0;
    areq.op    = ArithMul;
    areq.opa   = ProdW'(total_q);
    areq.opb   = DenW'(rows_q);
    case (state_q)
      StPrep: begin
        areq.start = cfg_i.cut_along_y && (cfg_i.row_height != '0);
        areq.op    = ArithDiv;
        areq.opa   = ProdW'(height);
        areq.opb   = DenW'(cfg_i.row_height);
      end
      StLineMul: begin
        areq.start = 1'b1;
        areq.opa   = ProdW'(rows_q[KeyW-1:1]);
        areq.opb   = DenW'(height);
      end
      StLineDiv: begin
        areq.start = 1'b1;
        areq.op    = ArithDiv;
        areq.opa   = tmp_q;
      end
      StE0Mul: begin
        areq.start = 1'b1;
      end
      StRMul: begin
        areq.start = 1'b1;
        areq.opb   = DenW'(rows_q[KeyW-1:1]);
      end
      StWalkMul: begin
        areq.start = 1'b1;
        areq.opa   = ProdW'(ent_q.area);
      end
      StXMul: begin
        areq.start = 1'b1;
        areq.opa   = ProdW'(below_q);
        areq.opb   = DenW'(width);
      end
      StXDiv: begin
        areq.start = 1'b1;
        areq.op    = ArithDiv;
        areq.opa   = tmp_q;
        areq.opb   = DenW'(total_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      total_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pj_q        <= '0;
      split_q     <= '0;
      mi_q        <= '0;
      cur_q       <= '0;
      min_q       <= '0;
      ent_q       <= '0;
      prefix_q    <= '0;
      below_q     <= '0;
      rows_q      <= '0;
      line_q      <= '0;
      cutkey_q    <= '0;
      tmp_q       <= '0;
      best_q      <= '0;
      r_q         <= '0;
      l_q         <= '0;
      cand_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // the emit state sets valid itself when the register frees up
      if (out_valid_q && !out_stall_i && state_q != StEmitOut) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StLoad: begin
          if (q_pop_o) begin
            if (q_data_i.keep) begin
              cnt_q   <= cnt_q + 1'b1;
              total_q <= total_q + SumW'(q_data_i.beat.footprint);
            end
            if (q_data_i.beat.last_cell) begin
              i_q     <= '0;
              state_q <= StSortRd;
            end
          end
        end
        StSortRd: begin
          j_q     <= i_q + 1'b1;
          state_q <= StSortFirst;
        end
        StSortFirst: begin
          cur_q <= rd_data_q;
          min_q <= rd_data_q;
          mi_q  <= i_q[AW-1:0];
          if (j_q < cnt_q) begin
            pj_q    <= j_q;
            j_q     <= j_q + 1'b1;
            state_q <= StSortScan;
          end else begin
            state_q <= StSwapA;
          end
        end
        StSortScan: begin
          // first strictly smaller key wins
          if (key_of(rd_data_q, cfg_i.cut_along_y) < key_of(min_q, cfg_i.cut_along_y)) begin
            min_q <= rd_data_q;
            mi_q  <= pj_q[AW-1:0];
          end
          if (j_q < cnt_q) begin
            pj_q <= j_q;
            j_q  <= j_q + 1'b1;
          end else begin
            state_q <= StSwapA;
          end
        end
        StSwapA: begin
          state_q <= StSwapB;
        end
        StSwapB: begin
          if (last_i) begin
            i_q      <= '0;
            prefix_q <= '0;
            l_q      <= '0;
            split_q  <= '0;
            state_q  <= StPrep;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= StSortRd;
          end
        end
        StPrep: begin
          if (cfg_i.cut_along_y) begin
            if (cfg_i.row_height == '0) begin
              rows_q  <= '0;
              cand_q  <= 1'b0;
              line_q  <= cfg_i.box_bottom;
              state_q <= StWalkRd;
            end else begin
              state_q <= StRowsW;
            end
          end else begin
            r_q     <= ProdW'(total_q);
            best_q  <= ProdW'({total_q, 1'b0});
            cand_q  <= (total_q != '0);
            state_q <= StWalkRd;
          end
        end
        StRowsW: begin
          if (arsp.done) begin
            rows_q <= arsp.result[KeyW-1:0];
            if (arsp.result[KeyW-1:0] == '0) begin
              cand_q  <= 1'b0;
              line_q  <= cfg_i.box_bottom;
              state_q <= StWalkRd;
            end else begin
              state_q <= StLineMul;
            end
          end
        end
        StLineMul: state_q <= StLineMulW;
        StLineMulW: begin
          if (arsp.done) begin
            tmp_q   <= arsp.result;
            state_q <= StLineDiv;
          end
        end
        StLineDiv: state_q <= StLineDivW;
        StLineDivW: begin
          if (arsp.done) begin
            line_q  <= cfg_i.box_bottom + arsp.result[KeyW-1:0];
            state_q <= StE0Mul;
          end
        end
        StE0Mul: state_q <= StE0MulW;
        StE0MulW: begin
          if (arsp.done) begin
            best_q  <= arsp.result;
            state_q <= StRMul;
          end
        end
        StRMul: state_q <= StRMulW;
        StRMulW: begin
          if (arsp.done) begin
            r_q     <= arsp.result;
            cand_q  <= (total_q != '0);
            state_q <= StWalkRd;
          end
        end
        StWalkRd: begin
          state_q <= StWalkDat;
        end
        StWalkDat: begin
          ent_q    <= rd_data_q;
          prefix_q <= prefix_nx;
          if (cand_q && cfg_i.cut_along_y) begin
            state_q <= StWalkMul;
          end else begin
            l_q     <= ProdW'({prefix_nx, 1'b0});
            state_q <= StWalkCmp;
          end
        end
        StWalkMul: state_q <= StWalkMulW;
        StWalkMulW: begin
          if (arsp.done) begin
            l_q     <= l_q + arsp.result;
            state_q <= StWalkCmp;
          end
        end
        StWalkCmp: begin
          if (upd) begin
            best_q   <= diff;
            split_q  <= i_q;
            below_q  <= prefix_q;
            cutkey_q <= key_of(ent_q, cfg_i.cut_along_y);
          end
          if (brk) begin
            i_q <= '0;
            if (cfg_i.cut_along_y) begin
              state_q <= StEmitRd;
            end else if (total_q != '0) begin
              state_q <= StXMul;
            end else begin
              line_q  <= cfg_i.box_left;
              state_q <= StEmitRd;
            end
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= StWalkRd;
          end
        end
        StXMul: state_q <= StXMulW;
        StXMulW: begin
          if (arsp.done) begin
            tmp_q   <= arsp.result;
            state_q <= StXDiv;
          end
        end
        StXDiv: state_q <= StXDivW;
        StXDivW: begin
          if (arsp.done) begin
            line_q  <= cfg_i.box_left + arsp.result[KeyW-1:0];
            state_q <= StEmitRd;
          end
        end
        StEmitRd: begin
          state_q <= StEmitOut;
        end
        StEmitOut: begin
          if (out_free) begin
            out_valid_q             <= 1'b1;
            out_q.sorted_cell_index <= rd_data_q.idx;
            out_q.goes_low          <= (i_q <= split_q);
            out_q.space_cut_line    <= line_q;
            out_q.cell_cut_coord    <= cutkey_q;
            out_q.area_below        <= below_q;
            out_q.area_above        <= total_q - below_q;
            out_q.last_result       <= last_i;
            if (last_i) begin
              cnt_q   <= '0;
              total_q <= '0;
              state_q <= StLoad;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= StEmitRd;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

endmodule

>>> hw/rtl/weighted_median_cell_split.sv
// ----------------------------------------------------------------------------
// weighted_median_cell_split
// splits a set of placed cells at the area-weighted median along x or y
// ----------------------------------------------------------------------------
// Load N cells one beat each (N up to MAX_CELLS, extra cells dropped); the
// beat with last_cell starts the split and N result beats follow in
// ascending coordinate order. Loading goes through a short queue. The run
// then does a selection sort over the single-read-port cell store, serial
// multiply and divide in y mode (row count, cut line and scaled target) or
// in x mode (cut line), a prefix walk over the sorted cells (one serial
// multiply per cell in y mode), and emits the result beats, each held while
// the receiver stalls. The block handles one set at a time; beats of the
// next set queue up meanwhile. The cell store needs no clearing pass after
// reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_median_cell_split import wmcs_pkg::*; #(
  parameter int unsigned MAX_CELLS = MaxCellsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                in_valid_i,
  input  in_beat_t            in_data_i,
  output logic                in_stall_o,
  // result beats
  output logic                out_valid_o,
  output out_beat_t           out_data_o,
  input  logic                out_stall_i,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_in, q_out;

  // configuration registers; the user must write them only between runs, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cut_along_y: 1'b0, box_left: '0, box_right: '0,
                 box_bottom: '0, box_top: '0, row_height: RhW'(1)};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegCutAlongY: cfg_q.cut_along_y <= cfg_data_i[0];
        RegBoxLeft:   cfg_q.box_left    <= cfg_data_i;
        RegBoxRight:  cfg_q.box_right   <= cfg_data_i;
        RegBoxBottom: cfg_q.box_bottom  <= cfg_data_i;
        RegBoxTop:    cfg_q.box_top     <= cfg_data_i;
        RegRowHeight: cfg_q.row_height  <= cfg_data_i[RhW-1:0];
        default: ;
      endcase
    end
  end

  // front: accepts beats and tags store overflow
  wmcs_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  // queue decouples beat intake from the sort engine
  wmcs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_out)
  );

  // back: store, sort, split search and result register
  wmcs_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/wmcs_checker.sv
// ----------------------------------------------------------------------------
// wmcs_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weighted_median_cell_split_defines.svh"

module wmcs_checker import wmcs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_beat_t out_data_i
);

  logic beat_done;
  assign beat_done = out_valid_i && !out_stall_i;

  // stalled result beat holds
  `WMCS_ASSERT_NEXT(a_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i))

  // nothing follows the final beat of a run straight away
  `WMCS_ASSERT_NEXT(a_run_end, beat_done && out_data_i.last_result, !out_valid_i)

  // split figures agree across a run
  `WMCS_ASSERT_NEXT(a_same_split, beat_done && !out_data_i.last_result,
    !out_valid_i || (out_data_i.area_below == $past(out_data_i.area_below) &&
    out_data_i.space_cut_line == $past(out_data_i.space_cut_line)))

  // once on the high side, the rest of the run stays there
  `WMCS_ASSERT_NEXT(a_side_order, beat_done && !out_data_i.last_result && !out_data_i.goes_low,
    !out_valid_i || !out_data_i.goes_low)

endmodule

bind weighted_median_cell_split wmcs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: weighted median cell split testbench
// drives sets of cells through the split block under random stalls and gaps,
// predicts every result beat in a scoreboard class and checks them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import wmcs_pkg::*;

  localparam int unsigned StoreDepth = MaxCellsDef;
  localparam int unsigned IdleLimit  = 20000;  // cycles with no beat moving
  localparam int unsigned SettleCyc  = 200;    // covers a run still in flight
  localparam int unsigned RandItems  = 400;
  localparam longint unsigned Mask38 = 64'h3F_FFFF_FFFF;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the registers and the cell store, predicts the
  // sorted split for every set and checks the result beats against it
  // --------------------------------------------------------------------------
  class split_scoreboard;
    bit              along_y;
    bit [KeyW-1:0]   left, right, bottom, top;
    bit [RhW-1:0]    row_h;
    in_beat_t        cells[StoreDepth];
    int unsigned     held;
    longint unsigned area_sum;
    out_beat_t       awaited[$];
    int unsigned     errors, beats_checked, sets_split;

    function new();
      along_y = 0; left = 0; right = 0; bottom = 0; top = 0; row_h = 1;
      held = 0; area_sum = 0; errors = 0; beats_checked = 0; sets_split = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        RegCutAlongY: along_y = d[0];
        RegBoxLeft:   left    = d;
        RegBoxRight:  right   = d;
        RegBoxBottom: bottom  = d;
        RegBoxTop:    top     = d;
        RegRowHeight: row_h   = d[RhW-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned key_of(in_beat_t c);
      return along_y ? c.cell_y : c.cell_x;
    endfunction

    function longint unsigned gap(longint unsigned a, longint unsigned b);
      return a >= b ? a - b : b - a;
    endfunction

    // an accepted input beat: store it, and on the last cell run the split
    function void note_cell(in_beat_t b);
      int unsigned     mi, cut;
      longint unsigned mk, prefix, below, line, best, ext, rows, half, lhs, rhs, e;
      in_beat_t        t;
      out_beat_t       r;
      cut = 0; prefix = 0; below = 0;
      if (held < StoreDepth) begin
        cells[held] = b;
        area_sum    = (area_sum + b.footprint) & Mask38;
        held++;
      end
      if (!b.last_cell) return;
      // selection sort, first strictly smallest key wins
      for (int i = 0; i < held; i++) begin
        mi = i; mk = key_of(cells[i]);
        for (int j = i + 1; j < held; j++)
          if (key_of(cells[j]) < mk) begin
            mi = j; mk = key_of(cells[j]);
          end
        t = cells[i]; cells[i] = cells[mi]; cells[mi] = t;
      end
      if (along_y) begin
        ext  = top >= bottom ? top - bottom : 0;
        rows = row_h != 0 ? ext / row_h : 0;
        half = rows / 2;
        line = bottom;
        if (rows != 0) begin
          line = bottom + (half * ext) / rows;
          best = area_sum * rows;
          for (int i = 0; i < held; i++) begin
            prefix += cells[i].footprint;
            if (area_sum == 0) continue;
            lhs = prefix * rows;
            rhs = half * area_sum;
            e   = gap(lhs, rhs);
            if (e < best) begin
              best = e; cut = i;
            end
            if (lhs >= rhs) break;
          end
        end
        for (int i = 0; i <= cut && i < held; i++) below += cells[i].footprint;
      end else begin
        ext  = right >= left ? right - left : 0;
        best = 2 * area_sum;
        for (int i = 0; i < held; i++) begin
          prefix += cells[i].footprint;
          if (area_sum == 0) continue;
          e = gap(2 * prefix, area_sum);
          if (e < best) begin
            best = e; cut = i;
          end
          if (2 * prefix > area_sum) break;
        end
        for (int i = 0; i <= cut && i < held; i++) below += cells[i].footprint;
        line = left;
        if (area_sum != 0) line = left + (below * ext) / area_sum;
      end
      below &= Mask38;
      for (int i = 0; i < held; i++) begin
        r.sorted_cell_index = cells[i].cell_index;
        r.goes_low          = (i <= cut);
        r.space_cut_line    = line[KeyW-1:0];
        r.cell_cut_coord    = KeyW'(key_of(cells[cut]));
        r.area_below        = SumW'(below);
        r.area_above        = SumW'((area_sum - below) & Mask38);
        r.last_result       = (i + 1 == held);
        awaited = {awaited, r};
      end
      held = 0; area_sum = 0; sets_split++;
    endfunction

    function void field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_beat_t g);
      out_beat_t x;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, g);
        errors++;
        return;
      end
      x = awaited.pop_front();
      beats_checked++;
      field("sorted_cell_index", x.sorted_cell_index, g.sorted_cell_index);
      field("goes_low",          x.goes_low,          g.goes_low);
      field("space_cut_line",    x.space_cut_line,    g.space_cut_line);
      field("cell_cut_coord",    x.cell_cut_coord,    g.cell_cut_coord);
      field("area_below",        x.area_below,        g.area_below);
      field("area_above",        x.area_above,        g.area_above);
      field("last_result",       x.last_result,       g.last_result);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  in_beat_t            in_data_i = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_beat_t           out_data_o;
  logic                out_stall_i = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  split_scoreboard sb = new();
  int unsigned     idle_cycles = 0;
  int unsigned     sent = 0;
  int unsigned     out_hold = 0;   // stall cycles left before the next result
  bit              no_gaps = 0;    // stretches with neither side idling

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  weighted_median_cell_split u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // monitors: sample both channels at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_cell(in_data_i);
        idle_cycles = 0;
      end else if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        out_hold = no_gaps ? 0 : $urandom_range(0, 13);
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog, no beat moved for %0d cycles", $time, IdleLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // receiver stall, drawn per result beat
  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // wait for every awaited result, then let a run still in flight settle
  task automatic drain();
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // one input beat; valid stays high across back-to-back beats
  task automatic send_cell(in_beat_t b);
    int unsigned wait_cyc;
    wait_cyc = no_gaps ? 0 : $urandom_range(0, 13);
    if (wait_cyc != 0) begin
      in_valid_i <= 1'b0;
      repeat (wait_cyc) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic park();
    in_valid_i <= 1'b0;
  endtask

  // random cell; coordinates sometimes squeezed so that keys tie
  function automatic in_beat_t rand_cell(bit last);
    in_beat_t c;
    c.cell_index = $urandom_range(0, 63);
    case ($urandom_range(0, 3))
      0: begin
        c.cell_x = $urandom_range(0, 3); c.cell_y = $urandom_range(0, 3);
      end
      default: begin
        c.cell_x = $urandom(); c.cell_y = $urandom();
      end
    endcase
    case ($urandom_range(0, 5))
      0:       c.footprint = 0;
      1:       c.footprint = $urandom_range(0, 20);
      2:       c.footprint = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: c.footprint = $urandom();
    endcase
    c.last_cell = last;
    return c;
  endfunction

  task automatic send_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_cell(rand_cell(i + 1 == n));
  endtask

  task automatic configure(bit y, int l, int r, int b, int t, int rh);
    write_reg(RegCutAlongY, CfgDataW'(y));
    write_reg(RegBoxLeft, CfgDataW'(l));
    write_reg(RegBoxRight, CfgDataW'(r));
    write_reg(RegBoxBottom, CfgDataW'(b));
    write_reg(RegBoxTop, CfgDataW'(t));
    write_reg(RegRowHeight, CfgDataW'(rh));
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    in_beat_t    c;
    int unsigned target, n;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: x mode over the whole range
    configure(0, 0, 24'hFF_FFFF, 0, 24'hFF_FFFF, 1);
    // single cell at every field maximum
    c = '{cell_index: 63, cell_x: 24'hFF_FFFF, cell_y: 24'hFF_FFFF,
          footprint: 32'hFFFF_FFFF, last_cell: 1'b1};
    send_cell(c);
    // single cell at every field minimum
    send_cell('{cell_index: 0, cell_x: 0, cell_y: 0, footprint: 0, last_cell: 1'b1});
    // zero total area over several cells
    for (int i = 0; i < 3; i++)
      send_cell('{cell_index: i, cell_x: 9 - i, cell_y: i, footprint: 0,
                  last_cell: i == 2});
    park();
    // sender holds off until the block has emptied
    drain();
    // equal halves: break rule on an exact half, plus tied keys
    for (int i = 0; i < 4; i++)
      send_cell('{cell_index: 10 + i, cell_x: 5, cell_y: 7, footprint: 100,
                  last_cell: i == 3});
    park();
    drain();
    // y mode, rows of one so the target fraction is zero
    configure(1, 0, 0, 0, 10, 10);
    for (int i = 0; i < 3; i++)
      send_cell('{cell_index: 20 + i, cell_x: i, cell_y: 30 - i, footprint: 1 << i,
                  last_cell: i == 2});
    park();
    drain();

    // random part over several register settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure(0, 0, 24'hFF_FFFF, 0, 24'hFF_FFFF, 1);
        1: configure(1, 0, 24'hFF_FFFF, 0, 24'hFF_FFFF, 1);
        2: configure(1, 5, 9, 100, 1100, 300);
        3: configure(1, 0, 0, 24'hFF_FFFF, 24'hFF_FFFF, 0);     // no rows
        4: configure(0, 24'hFF_FFFF, 0, 500, 4, 65535);         // inverted box
        5: configure(1, 0, 0, 0, 24'hFF_FFFF, 16'hFFFF);
        6: configure(1, 0, 0, 24'hFF_FFFF, 0, 7);               // inverted y
        default: configure($urandom_range(0, 1), $urandom(), $urandom(),
                           $urandom_range(0, 1000), $urandom(), $urandom_range(1, 65535));
      endcase
      target = sent + RandItems / 8;
      while (sent < target) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 15))
          0:       n = $urandom_range(30, 36);   // full store and dropped cells
          default: n = $urandom_range(1, 8);
        endcase
        send_set(n);
      end
      park();
      no_gaps = 0;
      drain();
    end

    $display("covered %0d input beats in %0d sets, %0d result beats checked",
             sent, sb.sets_split, sb.beats_checked);
    $display("both split axes, empty and inverted boxes, zero rows and full stores");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results still awaited", sb.errors, sb.awaited.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
